// ===== rtl/core/kahn_topological_sorter_unit_defines.svh =====
// Assertion macros shared by the topological sorter RTL.
`ifndef KAHN_TOPOLOGICAL_SORTER_UNIT_DEFINES_SVH
`define KAHN_TOPOLOGICAL_SORTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk and quiet while arst_n is low.
`define KTS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorter check failed in the same cycle");

// Next-cycle implication, checked on clk and quiet while arst_n is low.
`define KTS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorter check failed one cycle later");

`endif

// ===== rtl/core/kts_pkg.sv =====
// Shared types and codes of the topological sorter.
`default_nettype none
package kts_pkg;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SORT = 1'b1;

	localparam logic [1:0] STATUS_NODE      = 2'd0;
	localparam logic [1:0] STATUS_SELF_LOOP = 2'd1;
	localparam logic [1:0] STATUS_CYCLE     = 2'd2;

	// Control broadcast from the sequencer to every cell of the row.
	typedef struct packed {
		logic       load;
		logic [4:0] src;
		logic       init;
		logic       emit;
		logic [4:0] emit_id;
	} kts_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/kts_cell.sv =====
// One node cell: holds the node's incoming-edge column and its sort state.
`default_nettype none
module kts_cell import kts_pkg::*; #(
	parameter int CAP = 32,
	parameter int IDX = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire kts_ctrl_t      ctrl,
	input  wire logic           load_bit,
	input  wire logic [CAP-1:0] mask,
	input  wire logic           ready_in,
	output logic                ready_out,
	output logic                sel,
	input  wire logic           loop_in,
	output logic                loop_out
);

	localparam int IDXW = $clog2(CAP);

	logic [CAP-1:0] col_q;
	logic [CAP-1:0] work_q;
	logic           done_q;
	logic           act_q;
	logic           ready;

	// A node is ready once it is in use, not yet emitted and has no live input.
	assign ready     = act_q & ~done_q & ~(|work_q);
	assign sel       = ready & ~ready_in;
	assign ready_out = ready_in | ready;
	assign loop_out  = loop_in | (mask[IDX] & col_q[IDX]);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			col_q[ctrl.src[IDXW-1:0]] <= load_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q <= '0;
			done_q <= 1'b0;
			act_q  <= 1'b0;
		end else if (ctrl.init) begin
			work_q <= col_q & mask;
			done_q <= 1'b0;
			act_q  <= mask[IDX];
		end else if (ctrl.emit) begin
			work_q[ctrl.emit_id[IDXW-1:0]] <= 1'b0;
			if (sel) begin
				done_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/kahn_topological_sorter_unit.sv =====
// Kahn topological sorter over a row of node cells. A load word (operation 0)
// writes one adjacency row and is taken every cycle the input is not stalled;
// it gives no result. A sort word (operation 1) is checked for self-loops in
// the cycle it is accepted: a self-loop answers with one error word at once.
// Otherwise the cells take a working copy and, from the next cycle on, the
// sorter emits one node per cycle while the output is not stalled (lowest
// ready index first); an acyclic graph ends on a node word with last set,
// a cyclic one on a cycle error word. The rate is set by the single
// priority chain through the cells, which picks one node per cycle. The
// input is stalled while a sort runs and while a result waits on a stalled
// output. node_count may be written only while the block is idle.
`default_nettype none
`include "kahn_topological_sorter_unit_defines.svh"
module kahn_topological_sorter_unit import kts_pkg::*; #(
	parameter int MAX_NODES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        operation,
	input  wire logic [4:0]  row_index,
	input  wire logic [31:0] row_bits,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [4:0]       node_id,
	output logic [1:0]       status,
	output logic             last,
	input  wire logic        node_count_we,
	input  wire logic [5:0]  node_count_wdata
);

	localparam int CAP  = (MAX_NODES < 32) ? MAX_NODES : 32;
	localparam int IDXW = $clog2(CAP);
	localparam int CNTW = $clog2(CAP + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic            state_q;
	logic [5:0]      node_count_q;
	logic [CNTW-1:0] n_q;
	logic [CNTW-1:0] cnt_q;
	logic [CNTW-1:0] n_eff;
	logic [CAP-1:0]  mask;
	logic            out_valid_q;
	logic [4:0]      node_id_q;
	logic [1:0]      status_q;
	logic            last_q;

	logic            in_acc;
	logic            load_acc;
	logic            sort_acc;
	logic            can_load;
	logic            step;
	logic            last_node;
	logic            any_ready;
	logic            self_loop;
	logic [IDXW-1:0] sel_id;
	logic [CAP-1:0]  sel_vec;
	logic [CAP:0]    ready_c;
	logic [CAP:0]    loop_c;
	kts_ctrl_t       ctrl;

	assign in_acc   = in_valid & ~in_stall;
	assign load_acc = in_acc & (operation == OP_LOAD) & ({1'b0, row_index} < 6'(CAP));
	assign sort_acc = in_acc & (operation == OP_SORT);
	assign can_load = ~out_valid_q | ~out_stall;
	assign in_stall = (state_q == ST_RUN) | (out_valid_q & out_stall);
	assign step     = (state_q == ST_RUN) & can_load;

	// The run ends on the node that brings the emitted count up to n.
	assign last_node = ((cnt_q + CNTW'(1)) == n_q);

	always_comb begin
		if (node_count_q == 6'd0) begin
			n_eff = CNTW'(1);
		end else if (node_count_q > 6'(CAP)) begin
			n_eff = CNTW'(CAP);
		end else begin
			n_eff = CNTW'(node_count_q);
		end
	end

	always_comb begin
		for (int s = 0; s < CAP; s++) begin
			mask[s] = (CNTW'(s) < n_eff);
		end
	end

	always_comb begin
		sel_id = '0;
		for (int i = 0; i < CAP; i++) begin
			if (sel_vec[i]) begin
				sel_id = IDXW'(i);
			end
		end
	end

	always_comb begin
		ctrl.load    = load_acc;
		ctrl.src     = row_index;
		ctrl.init    = sort_acc & ~self_loop;
		ctrl.emit    = step & any_ready;
		ctrl.emit_id = 5'(sel_id);
	end

	assign ready_c[0] = 1'b0;
	assign loop_c[0]  = 1'b0;
	assign any_ready  = ready_c[CAP];
	assign self_loop  = loop_c[CAP];

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		kts_cell #(
			.CAP (CAP),
			.IDX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.load_bit  (row_bits[i]),
			.mask      (mask),
			.ready_in  (ready_c[i]),
			.ready_out (ready_c[i+1]),
			.sel       (sel_vec[i]),
			.loop_in   (loop_c[i]),
			.loop_out  (loop_c[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 6'd32;
		end else if (node_count_we) begin
			node_count_q <= node_count_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			n_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (sort_acc & ~self_loop) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
						n_q     <= n_eff;
					end
				end
				ST_RUN: begin
					if (step) begin
						if (any_ready) begin
							cnt_q <= cnt_q + CNTW'(1);
						end
						if (~any_ready | last_node) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((sort_acc & self_loop) | step) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q & ~out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sort_acc & self_loop) begin
			node_id_q <= 5'd0;
			status_q  <= STATUS_SELF_LOOP;
			last_q    <= 1'b1;
		end else if (step) begin
			if (any_ready) begin
				node_id_q <= 5'(sel_id);
				status_q  <= STATUS_NODE;
				last_q    <= last_node;
			end else begin
				node_id_q <= 5'd0;
				status_q  <= STATUS_CYCLE;
				last_q    <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign node_id   = node_id_q;
	assign status    = status_q;
	assign last      = last_q;

	`KTS_ASSERT_IMP(a_sel_onehot, 1'b1, $onehot0(sel_vec))
	`KTS_ASSERT_IMP(a_run_stalls, state_q == ST_RUN, in_stall)
	`KTS_ASSERT_IMP(a_cnt_bound, state_q == ST_RUN, cnt_q < n_q)
	`KTS_ASSERT_NXT(a_last_ends, step & any_ready & last_node, state_q == ST_IDLE)

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the Kahn topological sorter unit: directed table, then random graphs.
module testbench;
	import kts_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_WORDS = 220;

	typedef struct packed {
		logic [4:0] id;
		logic [1:0] status;
		logic       last;
	} sort_word_t;

	typedef enum logic [1:0] {STEP_CFG, STEP_LOAD, STEP_SORT} step_kind_t;

	typedef struct {
		step_kind_t  kind;
		logic [4:0]  idx;
		logic [31:0] bits;
		logic        typed;
		sort_word_t  want;
	} plan_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = OP_LOAD;
	logic [4:0]  row_index = 5'd0;
	logic [31:0] row_bits = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [4:0]  node_id;
	logic [1:0]  status;
	logic        last;
	logic        node_count_we = 1'b0;
	logic [5:0]  node_count_wdata = 6'd0;

	// Expectation carried alongside the payload of a sort word whose answer is typed in.
	logic        typed_now = 1'b0;
	sort_word_t  want_now = '0;

	logic [31:0] adj_rows [32];
	logic [31:0] work_edges [32];
	logic [31:0] rows_loaded = '0;
	logic [5:0]  nodes_in_use = 6'd32;
	sort_word_t  order_q [$];
	sort_word_t  head;
	plan_row_t   plan_q [$];
	logic        steady = 1'b0;
	int          errors = 0;
	int          words_in = 0;
	int          sorts_run = 0;
	int          words_out = 0;
	int          settings = 0;

	kahn_topological_sorter_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.row_index        (row_index),
		.row_bits         (row_bits),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.node_id          (node_id),
		.status           (status),
		.last             (last),
		.node_count_we    (node_count_we),
		.node_count_wdata (node_count_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int active_nodes(input logic [5:0] raw);
		if (raw == 6'd0)
			return 1;
		if (raw > 6'd32)
			return 32;
		return int'(raw);
	endfunction

	function automatic logic [31:0] node_mask(input int n);
		return (n >= 32) ? 32'hFFFF_FFFF : (32'd1 << n) - 32'd1;
	endfunction

	function automatic sort_word_t word_of(input logic [4:0] id, input logic [1:0] st,
			input logic lst);
		sort_word_t w;
		w.id = id;
		w.status = st;
		w.last = lst;
		return w;
	endfunction

	function automatic void expect_word(input sort_word_t w);
		order_q = {order_q, w};
	endfunction

	function automatic logic [31:0] pending_inputs();
		logic [31:0] acc;
		acc = '0;
		for (int s = 0; s < 32; s++)
			acc |= work_edges[s];
		return acc;
	endfunction

	// Expected order for a sort word, lowest ready node first.
	function automatic void predict_sort();
		logic [31:0] mask;
		logic [31:0] ready;
		logic [31:0] row;
		int n;
		int pick;
		n = active_nodes(nodes_in_use);
		mask = node_mask(n);
		for (int s = 0; s < n; s++)
			if (adj_rows[s][s]) begin
				expect_word(word_of(5'd0, STATUS_SELF_LOOP, 1'b1));
				return;
			end
		for (int s = 0; s < 32; s++)
			work_edges[s] = (s < n) ? adj_rows[s] & mask : '0;
		ready = mask & ~pending_inputs();
		while (ready != '0) begin
			pick = 0;
			while (!ready[pick])
				pick++;
			ready[pick] = 1'b0;
			row = work_edges[pick];
			work_edges[pick] = '0;
			ready |= row & ~pending_inputs();
			expect_word(word_of(pick[4:0], STATUS_NODE,
				ready == '0 && pending_inputs() == '0));
		end
		if (pending_inputs() != '0)
			expect_word(word_of(5'd0, STATUS_CYCLE, 1'b1));
	endfunction

	// Prediction on every accepted input word, then the check of every accepted result word.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			words_in++;
			if (operation == OP_LOAD) begin
				adj_rows[row_index] = row_bits;
			end else begin
				sorts_run++;
				if (typed_now)
					expect_word(want_now);
				else
					predict_sort();
			end
		end
		if (arst_n && out_valid && !out_stall) begin
			words_out++;
			if (order_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, node_id %0d status %0d last %0d",
					$time, node_id, status, last);
			end else begin
				head = order_q.pop_front();
				if (node_id !== head.id) begin
					errors++;
					$display("%0t: node_id expected %0d, got %0d", $time, head.id, node_id);
				end
				if (status !== head.status) begin
					errors++;
					$display("%0t: status expected %0d, got %0d", $time, head.status, status);
				end
				if (last !== head.last) begin
					errors++;
					$display("%0t: last expected %0d, got %0d", $time, head.last, last);
				end
			end
		end
	end

	always @(posedge clk)
		out_stall <= !steady && ($urandom_range(99) < 22);

	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send_word(input logic op, input logic [4:0] idx, input logic [31:0] bits,
			input logic typed = 1'b0, input sort_word_t want = '0);
		while (!steady && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		row_index <= idx;
		row_bits <= bits;
		typed_now <= typed;
		want_now <= want;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		if (op == OP_LOAD)
			rows_loaded[idx] = 1'b1;
	endtask

	// Let every expected word drain and the block fall idle.
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (order_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_node_count(input logic [5:0] value);
		settle();
		node_count_we <= 1'b1;
		node_count_wdata <= value;
		@(posedge clk);
		node_count_we <= 1'b0;
		nodes_in_use = value;
		settings++;
	endtask

	function automatic void plan_add(input step_kind_t kind, input logic [4:0] idx,
			input logic [31:0] bits, input logic typed = 1'b0, input logic [1:0] st = 2'd0,
			input logic lst = 1'b0);
		plan_row_t r;
		r.kind = kind;
		r.idx = idx;
		r.bits = bits;
		r.typed = typed;
		r.want = word_of(5'd0, st, lst);
		plan_q = {plan_q, r};
	endfunction

	// One graph on n nodes: a random DAG, sometimes broken by a back edge or a self-loop.
	task automatic run_graph(input int n);
		logic [31:0] mask;
		logic [31:0] rows [32];
		int perm [32];
		int roll;
		int density;
		int start;
		int i;
		int j;
		int s;
		int tmp;
		logic partial;
		mask = node_mask(n);
		for (i = 0; i < 32; i++) begin
			perm[i] = i;
			rows[i] = '0;
		end
		for (i = n - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		density = $urandom_range(10, 60);
		for (i = 0; i < n; i++)
			for (j = i + 1; j < n; j++)
				if ($urandom_range(99) < density)
					rows[perm[i]][perm[j]] = 1'b1;
		roll = $urandom_range(99);
		if (roll < 20 && n > 1) begin
			i = $urandom_range(n - 2);
			j = $urandom_range(n - 1, i + 1);
			rows[perm[j]][perm[i]] = 1'b1;
		end else if (roll < 30) begin
			i = $urandom_range(n - 1);
			rows[i][i] = 1'b1;
		end
		// A partial reload only rewrites some rows, so all rows in use must hold data already.
		partial = roll >= 85 && (rows_loaded & mask) == mask;
		start = $urandom_range(n - 1);
		for (i = 0; i < n; i++) begin
			s = (start + i) % n;
			if (!partial || $urandom_range(2) == 0)
				send_word(OP_LOAD, s[4:0], rows[s] | ($urandom_range(1) ? $urandom & ~mask : 32'd0));
		end
		if (n < 32 && $urandom_range(3) == 0) begin
			s = $urandom_range(31, n);
			send_word(OP_LOAD, s[4:0], $urandom);
		end
		tmp = $urandom;
		send_word(OP_SORT, tmp[4:0], $urandom);
	endtask

	initial begin : stimulus
		int phase;
		int n;
		int graphs;
		int roll;
		logic [5:0] value;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: node count extremes, self-loops, cycles, ignored rows and columns.
		plan_add(STEP_CFG, 5'd0, 32'd0);
		plan_add(STEP_LOAD, 5'd0, 32'hFFFF_FFFE);
		plan_add(STEP_SORT, 5'd0, 32'd0, 1'b1, STATUS_NODE, 1'b1);
		plan_add(STEP_LOAD, 5'd0, 32'hFFFF_FFFF);
		plan_add(STEP_SORT, 5'd31, 32'hFFFF_FFFF, 1'b1, STATUS_SELF_LOOP, 1'b1);
		plan_add(STEP_CFG, 5'd0, 32'd2);
		plan_add(STEP_LOAD, 5'd0, 32'h0000_0002);
		plan_add(STEP_LOAD, 5'd1, 32'h0000_0001);
		plan_add(STEP_SORT, 5'd0, 32'd0, 1'b1, STATUS_CYCLE, 1'b1);
		plan_add(STEP_LOAD, 5'd1, 32'hFFFF_FFFC);
		plan_add(STEP_SORT, 5'd0, 32'd0);
		plan_add(STEP_LOAD, 5'd31, 32'hFFFF_FFFF);
		plan_add(STEP_SORT, 5'd0, 32'd0);
		plan_add(STEP_CFG, 5'd0, 32'd3);
		plan_add(STEP_LOAD, 5'd0, 32'h0000_0004);
		plan_add(STEP_LOAD, 5'd1, 32'h0000_0001);
		plan_add(STEP_LOAD, 5'd2, 32'h0000_0000);
		plan_add(STEP_SORT, 5'd0, 32'd0);
		plan_add(STEP_LOAD, 5'd2, 32'h0000_0001);
		plan_add(STEP_SORT, 5'd0, 32'd0);
		plan_add(STEP_LOAD, 5'd0, 32'h0000_0000);
		plan_add(STEP_LOAD, 5'd1, 32'h0000_0000);
		plan_add(STEP_LOAD, 5'd2, 32'h0000_0000);
		plan_add(STEP_SORT, 5'd0, 32'd0);
		plan_add(STEP_CFG, 5'd0, 32'd1);
		plan_add(STEP_LOAD, 5'd0, 32'h8000_0000);
		plan_add(STEP_SORT, 5'd0, 32'd0, 1'b1, STATUS_NODE, 1'b1);

		foreach (plan_q[k]) begin
			case (plan_q[k].kind)
				STEP_CFG: set_node_count(plan_q[k].bits[5:0]);
				STEP_LOAD: send_word(OP_LOAD, plan_q[k].idx, plan_q[k].bits);
				default: send_word(OP_SORT, plan_q[k].idx, plan_q[k].bits, plan_q[k].typed,
					plan_q[k].want);
			endcase
		end

		// Random part: mostly small graphs, the full width only in the first two settings.
		phase = 0;
		while (words_in < plan_q.size() + RANDOM_WORDS) begin
			roll = $urandom_range(99);
			if (phase == 0)
				value = 6'd32;
			else if (phase == 1)
				value = 6'd63;
			else if (roll < 10)
				value = 6'd0;
			else if (roll < 25)
				value = 6'($urandom_range(20, 10));
			else
				value = 6'($urandom_range(9, 1));
			set_node_count(value);
			steady = (phase >= 3 && phase <= 5);
			n = active_nodes(value);
			graphs = (n >= 16) ? 1 : $urandom_range(4, 2);
			repeat (graphs) run_graph(n);
			phase++;
		end
		steady = 1'b0;

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sorter run: %0d input words with %0d sorts, %0d result words checked",
			words_in, sorts_run, words_out);
		$display("across %0d node count settings, including 0, 1, 32 and 63.", settings);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
